@@ hw/rtl/pa_pkg.sv @@
// Shared constants, codes and types of the primitive assembly block.
package pa_pkg;

  localparam int VidW      = 16;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // input item kinds
  localparam logic [1:0] KindBegin  = 2'd0;
  localparam logic [1:0] KindVertex = 2'd1;
  localparam logic [1:0] KindEnd    = 2'd2;

  // primitive modes
  localparam logic [3:0] ModePoints    = 4'd0;
  localparam logic [3:0] ModeLineStrip = 4'd1;
  localparam logic [3:0] ModeLineLoop  = 4'd2;
  localparam logic [3:0] ModeLines     = 4'd3;
  localparam logic [3:0] ModeTriStrip  = 4'd4;
  localparam logic [3:0] ModeTriFan    = 4'd5;
  localparam logic [3:0] ModeTris      = 4'd6;
  localparam logic [3:0] ModeQuads     = 4'd7;
  localparam logic [3:0] ModeQuadStrip = 4'd8;

  // result primitive kinds
  localparam logic [1:0] PrimNone  = 2'd0;
  localparam logic [1:0] PrimPoint = 2'd1;
  localparam logic [1:0] PrimLine  = 2'd2;
  localparam logic [1:0] PrimTri   = 2'd3;

  // status codes
  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatInvOp   = 2'd1;
  localparam logic [1:0] StatInvEnum = 2'd2;

  typedef struct packed {
    logic [1:0]      prim_kind;
    logic [VidW-1:0] vert_a;
    logic [VidW-1:0] vert_b;
    logic [VidW-1:0] vert_c;
    logic [1:0]      status;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            room;
  } fifo_stat_t;

  function automatic res_t mk_res(logic [1:0] pk, logic [VidW-1:0] a, logic [VidW-1:0] b,
                                  logic [VidW-1:0] c, logic [1:0] st);
    res_t r;
    r.prim_kind = pk;
    r.vert_a    = a;
    r.vert_b    = b;
    r.vert_c    = c;
    r.status    = st;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

@@ hw/rtl/pa_if.sv @@
// Valid/ready channel interfaces for item input and primitive output.
interface pa_in_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [3:0]              mode;
  logic [pa_pkg::VidW-1:0] vertex_id;

  modport source (output valid, kind, mode, vertex_id, input ready);
  modport sink   (input valid, kind, mode, vertex_id, output ready);
endinterface

interface pa_out_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              prim_kind;
  logic [pa_pkg::VidW-1:0] vert_a;
  logic [pa_pkg::VidW-1:0] vert_b;
  logic [pa_pkg::VidW-1:0] vert_c;
  logic [1:0]              status;
  logic                    last;

  modport source (output valid, prim_kind, vert_a, vert_b, vert_c, status, last, input ready);
  modport sink   (input valid, prim_kind, vert_a, vert_b, vert_c, status, last, output ready);
endinterface

@@ hw/rtl/pa_res_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per cycle.
module pa_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  pa_pkg::res_t       push0_i,
  input  pa_pkg::res_t       push1_i,
  input  logic               pop_i,
  output pa_pkg::res_t       head_o,
  output pa_pkg::fifo_stat_t stat_o
);

  pa_pkg::res_t                  mem_q [pa_pkg::FifoDepth];
  logic [pa_pkg::PtrW-1:0]       wr_q;
  logic [pa_pkg::PtrW-1:0]       rd_q;
  logic [pa_pkg::CntW-1:0]       cnt_q;
  logic [pa_pkg::PtrW-1:0]       wr_nxt;

  assign wr_nxt = pa_pkg::PtrW'(wr_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= pa_pkg::PtrW'(wr_q + pa_pkg::PtrW'(push_n_i));
      rd_q  <= pa_pkg::PtrW'(rd_q + pa_pkg::PtrW'(pop_i));
      cnt_q <= pa_pkg::CntW'(cnt_q + pa_pkg::CntW'(push_n_i) - pa_pkg::CntW'(pop_i));
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.count = cnt_q;
  // room for the worst case of two results from one item
  assign stat_o.room  = (cnt_q <= pa_pkg::CntW'(pa_pkg::FifoDepth - 2));

endmodule

@@ hw/rtl/primitive_assembly_core.sv @@
// Primitive assembly top level: begin/vertex/end items in, primitive descriptors out.
// Input channel in_i carries kind (begin, vertex, end), mode (on begin) and vertex_id.
// Output channel out_o carries prim_kind, three vertex handles, status and last;
// last marks the final result caused by one input item. Items that cause no result
// (vertex while idle, unused kind code, vertices that do not complete a primitive)
// are consumed silently.
// An accepted item is registered in the item stage, assembled there once the queue has
// room and written to a four-entry result queue; its first result is then presented on
// out_o from the queue head and transfers when out_o.ready is high.
// Throughput: one item per cycle unless the assembly stage holds. It advances when
// the queue has room for two results, so a quad (two triangles per fourth vertex)
// never stalls a steady vertex stream while out_o takes one result per cycle.
// When the receiver stalls, results wait in the queue, the assembly stage holds its
// item once more than two results are waiting, and in_i.ready drops.
// Reset clears the open-primitive state and empties the queue; stored vertex handles
// are not cleared and are only read once vertices after a begin have refilled them.
module primitive_assembly_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pa_in_if.sink       in_i,
  pa_out_if.source    out_o
);

  // item stage
  logic                    stg_vld_q;
  logic [1:0]              stg_kind_q;
  logic [3:0]              stg_mode_q;
  logic [pa_pkg::VidW-1:0] stg_vid_q;

  // assembly state
  logic                    active_q, active_d;
  logic [3:0]              mode_q, mode_d;
  logic [1:0]              pos_q, pos_d;
  logic [1:0]              seen_q, seen_d;
  logic [pa_pkg::VidW-1:0] h1_q, h2_q, h3_q;
  logic [pa_pkg::VidW-1:0] loop_first_q, loop_first_d;
  logic [pa_pkg::VidW-1:0] fan_q, fan_d;
  logic                    shift_en;

  logic                    fire;
  logic                    pop;
  logic [1:0]              n;
  logic [1:0]              push_n;
  pa_pkg::res_t            r0, r1, head;
  pa_pkg::fifo_stat_t      fst;
  logic [pa_pkg::CntW-1:0] cnt_exp;
  logic [1:0]              seen_inc;

  assign fire       = stg_vld_q && fst.room;
  assign in_i.ready = !stg_vld_q || fst.room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_kind_q <= in_i.kind;
      stg_mode_q <= in_i.mode;
      stg_vid_q  <= in_i.vertex_id;
    end
  end

  assign seen_inc = (seen_q == 2'd3) ? seen_q : 2'(seen_q + 2'd1);

  always_comb begin
    active_d     = active_q;
    mode_d       = mode_q;
    pos_d        = pos_q;
    seen_d       = seen_q;
    loop_first_d = loop_first_q;
    fan_d        = fan_q;
    shift_en     = 1'b0;
    n            = 2'd0;
    r0           = pa_pkg::mk_res(pa_pkg::PrimNone, '0, '0, '0, pa_pkg::StatOk);
    r1           = r0;

    unique case (stg_kind_q)
      pa_pkg::KindBegin: begin
        n = 2'd1;
        if (active_q) begin
          r0.status = pa_pkg::StatInvOp;
        end else if (stg_mode_q > pa_pkg::ModeQuadStrip) begin
          r0.status = pa_pkg::StatInvEnum;
        end else begin
          active_d = 1'b1;
          mode_d   = stg_mode_q;
          pos_d    = 2'd0;
          seen_d   = 2'd0;
        end
      end
      pa_pkg::KindEnd: begin
        n = 2'd1;
        if (!active_q) begin
          r0.status = pa_pkg::StatInvOp;
        end else begin
          active_d = 1'b0;
          if (mode_q == pa_pkg::ModeLineLoop && seen_q > 2'd2) begin
            r0 = pa_pkg::mk_res(pa_pkg::PrimLine, h1_q, loop_first_q, '0, pa_pkg::StatOk);
          end
        end
      end
      pa_pkg::KindVertex: begin
        if (active_q) begin
          // h1..h3 hold the last three handles, newest first
          shift_en = 1'b1;
          unique case (mode_q)
            pa_pkg::ModePoints: begin
              n  = 2'd1;
              r0 = pa_pkg::mk_res(pa_pkg::PrimPoint, stg_vid_q, '0, '0, pa_pkg::StatOk);
            end
            pa_pkg::ModeLineStrip, pa_pkg::ModeLineLoop: begin
              if (seen_q == 2'd0) begin
                if (mode_q == pa_pkg::ModeLineLoop) begin
                  loop_first_d = stg_vid_q;
                end
                seen_d = 2'd1;
                pos_d  = 2'd1;
              end else begin
                n  = 2'd1;
                r0 = pa_pkg::mk_res(pa_pkg::PrimLine, h1_q, stg_vid_q, '0, pa_pkg::StatOk);
                if (mode_q == pa_pkg::ModeLineLoop) begin
                  seen_d = seen_inc;
                end
                pos_d = {1'b0, ~pos_q[0]};
              end
            end
            pa_pkg::ModeLines: begin
              if (pos_q == 2'd0) begin
                pos_d = 2'd1;
              end else begin
                n     = 2'd1;
                r0    = pa_pkg::mk_res(pa_pkg::PrimLine, h1_q, stg_vid_q, '0, pa_pkg::StatOk);
                pos_d = 2'd0;
              end
            end
            pa_pkg::ModeTriStrip, pa_pkg::ModeTriFan, pa_pkg::ModeTris: begin
              if (seen_q < 2'd2) begin
                if (mode_q == pa_pkg::ModeTriFan && seen_q == 2'd0) begin
                  fan_d = stg_vid_q;
                end
                seen_d = seen_inc;
              end else begin
                n  = 2'd1;
                r0 = pa_pkg::mk_res(pa_pkg::PrimTri,
                                    (mode_q == pa_pkg::ModeTriFan) ? fan_q : h2_q,
                                    h1_q, stg_vid_q, pa_pkg::StatOk);
                if (mode_q == pa_pkg::ModeTris) begin
                  seen_d = 2'd0;
                end
              end
              pos_d = 2'(pos_q + 2'd1);
            end
            pa_pkg::ModeQuads: begin
              if (seen_q < 2'd3) begin
                seen_d = seen_inc;
              end else begin
                n      = 2'd2;
                r0     = pa_pkg::mk_res(pa_pkg::PrimTri, h3_q, h2_q, h1_q, pa_pkg::StatOk);
                r1     = pa_pkg::mk_res(pa_pkg::PrimTri, h1_q, stg_vid_q, h3_q, pa_pkg::StatOk);
                seen_d = 2'd0;
              end
              pos_d = 2'(pos_q + 2'd1);
            end
            pa_pkg::ModeQuadStrip: begin
              if (seen_q < 2'd3 || !pos_q[0]) begin
                seen_d = seen_inc;
              end else begin
                n = 2'd2;
                // the first triangle swaps its leading handles except at ring position three
                if (pos_q[1]) begin
                  r0 = pa_pkg::mk_res(pa_pkg::PrimTri, h3_q, h2_q, h1_q, pa_pkg::StatOk);
                end else begin
                  r0 = pa_pkg::mk_res(pa_pkg::PrimTri, h2_q, h3_q, h1_q, pa_pkg::StatOk);
                end
                r1 = pa_pkg::mk_res(pa_pkg::PrimTri, h1_q, stg_vid_q, h3_q, pa_pkg::StatOk);
              end
              pos_d = 2'(pos_q + 2'd1);
            end
            default: begin
              n = 2'd0;
            end
          endcase
        end
      end
      default: begin
        n = 2'd0;
      end
    endcase

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mode_q   <= '0;
      pos_q    <= '0;
      seen_q   <= '0;
    end else if (fire) begin
      active_q <= active_d;
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      loop_first_q <= loop_first_d;
      fan_q        <= fan_d;
      if (shift_en) begin
        h1_q <= stg_vid_q;
        h2_q <= h1_q;
        h3_q <= h2_q;
      end
    end
  end

  assign push_n = fire ? n : 2'd0;
  assign pop    = out_o.valid && out_o.ready;

  pa_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (r0),
    .push1_i  (r1),
    .pop_i    (pop),
    .head_o   (head),
    .stat_o   (fst)
  );

  assign out_o.valid     = (fst.count != '0);
  assign out_o.prim_kind = head.prim_kind;
  assign out_o.vert_a    = head.vert_a;
  assign out_o.vert_b    = head.vert_b;
  assign out_o.vert_c    = head.vert_c;
  assign out_o.status    = head.status;
  assign out_o.last      = head.last;

  assign cnt_exp = pa_pkg::CntW'(fst.count + pa_pkg::CntW'(push_n) - pa_pkg::CntW'(pop));

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (mode_q <= pa_pkg::ModeQuadStrip))
    else $error("open primitive holds an illegal mode");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fst.count <= pa_pkg::CntW'(pa_pkg::FifoDepth))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (fst.count == $past(cnt_exp)))
    else $error("result queue count lost a transfer");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q && !fst.room) |=> (stg_vld_q && $stable(stg_kind_q) && $stable(stg_vid_q)))
    else $error("stalled item changed in assembly stage");

endmodule
